@@ design/vtq_pkg.sv @@
// ---------------------------------------------------------------------------
// vtq_pkg
// Shared types and constants for the versioned timer queue.
// ---------------------------------------------------------------------------
package vtq_pkg;
	localparam int unsigned SLOTS_DEF = 32;
	localparam int unsigned SLOT_W    = 5;
	localparam int unsigned CNT_W     = 6;
	localparam int unsigned TIME_W    = 64;
	localparam int unsigned GEN_W     = 32;
	localparam int unsigned CK_W      = 32;
	localparam int unsigned CAP_W     = 42;
	localparam int unsigned WAIT_W    = 63;
	localparam int unsigned FIRE_LIMIT = 32;

	localparam logic [1:0] MODE_SCHED  = 2'd0;
	localparam logic [1:0] MODE_CANCEL = 2'd1;
	localparam logic [1:0] MODE_TICK   = 2'd2;

	localparam logic [1:0] KIND_SCHED  = 2'd0;
	localparam logic [1:0] KIND_CANCEL = 2'd1;
	localparam logic [1:0] KIND_FIRE   = 2'd2;
	localparam logic [1:0] KIND_DONE   = 2'd3;

	localparam logic [0:0] REG_ACCEPTING = 1'd0;
	localparam logic [0:0] REG_MAX_WAIT  = 1'd1;

	typedef struct packed {
		logic [1:0]        kind;
		logic              accepted;
		logic [SLOT_W-1:0] slot;
		logic [GEN_W-1:0]  version;
		logic [CK_W-1:0]   cookie;
		logic [CNT_W-1:0]  pending;
		logic              empty;
		logic [WAIT_W-1:0] wait_us;
		logic              last;
	} result_t;

	function automatic logic [GEN_W-1:0] next_gen(input logic [GEN_W-1:0] g);
		logic [GEN_W-1:0] n;
		n = g + GEN_W'(2);
		if (n == '0) n = GEN_W'(2);
		return n;
	endfunction
endpackage

@@ design/vtq_slot_mem.sv @@
// ---------------------------------------------------------------------------
// vtq_slot_mem
// Per-slot run time and cookie store, one write and two read ports, read
// data registered.
// ---------------------------------------------------------------------------
module vtq_slot_mem #(
	parameter int unsigned SLOTS = vtq_pkg::SLOTS_DEF
) (
	input  logic                            clk,
	input  logic                            we,
	input  logic [vtq_pkg::SLOT_W-1:0]      waddr,
	input  logic [vtq_pkg::TIME_W-1:0]      wtime,
	input  logic [vtq_pkg::CK_W-1:0]        wcookie,
	input  logic [vtq_pkg::SLOT_W-1:0]      raddr_a,
	input  logic [vtq_pkg::SLOT_W-1:0]      raddr_b,
	output logic [vtq_pkg::TIME_W-1:0]      rtime_a,
	output logic [vtq_pkg::TIME_W-1:0]      rtime_b,
	output logic [vtq_pkg::CK_W-1:0]        rcookie_a
);
	logic [vtq_pkg::TIME_W-1:0] time_mem [SLOTS];
	logic [vtq_pkg::CK_W-1:0]   ck_mem   [SLOTS];

	always_ff @(posedge clk) begin
		if (we) begin
			time_mem[waddr] <= wtime;
			ck_mem[waddr]   <= wcookie;
		end
		rtime_a   <= time_mem[raddr_a];
		rtime_b   <= time_mem[raddr_b];
		rcookie_a <= ck_mem[raddr_a];
	end
endmodule

@@ design/vtq_heap_mem.sv @@
// ---------------------------------------------------------------------------
// vtq_heap_mem
// Heap order store: slot number per heap position, registered reads.
// ---------------------------------------------------------------------------
module vtq_heap_mem #(
	parameter int unsigned SLOTS = vtq_pkg::SLOTS_DEF
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [vtq_pkg::SLOT_W-1:0] waddr,
	input  logic [vtq_pkg::SLOT_W-1:0] wdata,
	input  logic [vtq_pkg::SLOT_W-1:0] raddr_a,
	input  logic [vtq_pkg::SLOT_W-1:0] raddr_b,
	output logic [vtq_pkg::SLOT_W-1:0] rdata_a,
	output logic [vtq_pkg::SLOT_W-1:0] rdata_b
);
	logic [vtq_pkg::SLOT_W-1:0] mem [SLOTS];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end
endmodule

@@ design/versioned_timer_queue_core.sv @@
// ---------------------------------------------------------------------------
// versioned_timer_queue_core
// Min-heap timer queue with generation-checked handles.
// ---------------------------------------------------------------------------
// channel | dir | handshake              | payload
// s_axis  | in  | s_tvalid/s_tready      | s_tdata, s_tuser(mode)
// m_axis  | out | m_tvalid/m_tready      | m_tdata, m_tuser(kind), m_tlast
// apb     | in  | psel/penable/pready    | paddr, pwdata, prdata
//
// One transaction at a time; a heap read goes through the heap memory, then the slot
// memory. Schedule sifts the new entry up, level by level. Cancel only marks the
// slot. Tick pops each due entry, moves the last entry to the root and sifts it
// down, and reports the popped entry unless it was cancelled.
// No clearing pass at reset (flags and generations in flops).
// The output register holds a result until m_tready; work stalls meanwhile.
module versioned_timer_queue_core #(
	parameter int unsigned SLOTS = vtq_pkg::SLOTS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// run_time_us[63:0], cookie[95:64], task_slot[100:96], task_version[132:101],
	// now_us[196:133], zero fill
	input  logic [199:0] s_tdata,
	input  logic [1:0]   s_tuser, // mode
	output logic         m_tvalid,
	input  logic         m_tready,
	// accepted[0], slot_out[5:1], version_out[37:6], cookie_out[69:38],
	// pending_count[75:70], heap_empty[76], wait_us[139:77], zero fill
	output logic [143:0] m_tdata,
	output logic [1:0]   m_tuser, // reply_kind
	output logic         m_tlast,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [63:0]  pwdata,
	output logic [63:0]  prdata,
	output logic         pready
);
	localparam int unsigned SW = vtq_pkg::SLOT_W;
	localparam int unsigned CW = vtq_pkg::CNT_W;
	localparam int unsigned FW = CW + 1;
	localparam int unsigned POOL = (SLOTS < 32) ? SLOTS : 32;

	localparam logic [4:0] ST_IDLE    = 5'd0;
	localparam logic [4:0] ST_PUSH_A  = 5'd1;
	localparam logic [4:0] ST_PUSH_W1 = 5'd2;
	localparam logic [4:0] ST_PUSH_W2 = 5'd3;
	localparam logic [4:0] ST_PUSH_C  = 5'd4;
	localparam logic [4:0] ST_TOP_A   = 5'd5;
	localparam logic [4:0] ST_TOP_W1  = 5'd6;
	localparam logic [4:0] ST_TOP_W2  = 5'd7;
	localparam logic [4:0] ST_TOP_C   = 5'd8;
	localparam logic [4:0] ST_POP_W1  = 5'd9;
	localparam logic [4:0] ST_POP_W2  = 5'd10;
	localparam logic [4:0] ST_POP_L   = 5'd11;
	localparam logic [4:0] ST_DN_A    = 5'd12;
	localparam logic [4:0] ST_DN_W1   = 5'd13;
	localparam logic [4:0] ST_DN_W2   = 5'd14;
	localparam logic [4:0] ST_DN_C    = 5'd15;
	localparam logic [4:0] ST_OUT     = 5'd16;

	logic [4:0] state_q, ret_q;
	logic accepting_q;
	logic [vtq_pkg::CAP_W-1:0] max_wait_q;
	logic [POOL-1:0] busy_q, canc_q;
	logic [vtq_pkg::GEN_W-1:0] gen_q [POOL];
	logic [CW-1:0] count_q;
	logic [vtq_pkg::TIME_W-1:0] now_q;
	logic [CW-1:0] idx_q;
	logic [SW-1:0] cur_slot_q, ha_q, hb_q;
	logic [vtq_pkg::TIME_W-1:0] cur_time_q;
	logic [FW-1:0] fired_q;
	logic fire_q;
	vtq_pkg::result_t res_q, stage_q, stage_d;
	logic res_v_q;

	// memory ports
	logic sm_we, hm_we;
	logic [SW-1:0] sm_waddr, sm_ra, sm_rb, hm_waddr, hm_wdata, hm_ra, hm_rb, hm_da, hm_db;
	logic [vtq_pkg::TIME_W-1:0] sm_wtime, sm_ta, sm_tb;
	logic [vtq_pkg::CK_W-1:0] sm_wck, sm_cka;

	vtq_slot_mem #(.SLOTS(POOL)) u_slot (
		.clk, .we(sm_we), .waddr(sm_waddr), .wtime(sm_wtime), .wcookie(sm_wck),
		.raddr_a(sm_ra), .raddr_b(sm_rb), .rtime_a(sm_ta), .rtime_b(sm_tb),
		.rcookie_a(sm_cka)
	);
	vtq_heap_mem #(.SLOTS(POOL)) u_heap (
		.clk, .we(hm_we), .waddr(hm_waddr), .wdata(hm_wdata),
		.raddr_a(hm_ra), .raddr_b(hm_rb), .rdata_a(hm_da), .rdata_b(hm_db)
	);

	// "a before b" compares on (time, slot)
	function automatic logic lt(input logic [vtq_pkg::TIME_W-1:0] ta,
		input logic [SW-1:0] sa, input logic [vtq_pkg::TIME_W-1:0] tb,
		input logic [SW-1:0] sb);
		return (ta != tb) ? (ta < tb) : (sa < sb);
	endfunction

	// lowest free slot
	logic free_found;
	logic [SW-1:0] free_slot;
	always_comb begin
		free_found = 1'b0;
		free_slot = '0;
		for (int i = POOL - 1; i >= 0; i--) begin
			if (!busy_q[i]) begin
				free_found = 1'b1;
				free_slot = SW'(i);
			end
		end
	end

	logic [SW-1:0] in_slot;
	logic [vtq_pkg::GEN_W-1:0] in_ver;
	assign in_slot = s_tdata[100:96];
	assign in_ver  = s_tdata[132:101];

	logic res_free;
	assign res_free = !res_v_q || m_tready;
	assign s_tready = (state_q == ST_IDLE) && res_free;

	// wait computation from the top entry's time
	logic [vtq_pkg::TIME_W-1:0] wdiff;
	logic [vtq_pkg::WAIT_W-1:0] wait_val;
	always_comb begin
		wdiff = (sm_ta > now_q) ? (sm_ta - now_q) : '0;
		if (max_wait_q != '0 && wdiff > {22'd0, max_wait_q})
			wdiff = {22'd0, max_wait_q};
		wait_val = wdiff[63] ? '1 : wdiff[62:0];
	end

	logic [CW-1:0] lidx, ridx, par, nxt_cnt;
	assign lidx = CW'({idx_q, 1'b0} + 1);
	assign ridx = CW'({idx_q, 1'b0} + 2);
	assign par = (idx_q - 1'b1) >> 1;
	assign nxt_cnt = count_q - 1'b1;

	logic cancel_ok, pop_go, up_move;
	assign cancel_ok = 32'(in_slot) < POOL && busy_q[in_slot] && !canc_q[in_slot] &&
		gen_q[in_slot] == in_ver;
	assign pop_go = count_q != '0 && fired_q != FW'(vtq_pkg::FIRE_LIMIT) && sm_ta <= now_q;
	assign up_move = lt(cur_time_q, cur_slot_q, sm_ta, hm_da);

	// down-sift pick
	logic l_ok, r_ok, pick_l, pick_r;
	always_comb begin
		l_ok = lidx < count_q;
		r_ok = ridx < count_q;
		pick_l = l_ok && lt(sm_ta, hm_da, cur_time_q, cur_slot_q);
		pick_r = r_ok && (pick_l ? lt(sm_tb, hm_db, sm_ta, hm_da)
			: lt(sm_tb, hm_db, cur_time_q, cur_slot_q));
	end

	assign hm_ra = ha_q;
	assign hm_rb = hb_q;
	assign sm_ra = hm_da;
	assign sm_rb = hm_db;
	assign sm_waddr = free_slot;
	assign sm_wtime = s_tdata[63:0] ^ {1'b1, 63'd0};
	assign sm_wck = s_tdata[95:64];
	assign sm_we = s_tready && s_tvalid && s_tuser == vtq_pkg::MODE_SCHED &&
		accepting_q && free_found;

	always_comb begin
		hm_we = 1'b0;
		hm_waddr = idx_q[SW-1:0];
		hm_wdata = cur_slot_q;
		unique case (state_q)
			ST_PUSH_A: hm_we = (idx_q == '0);
			ST_PUSH_C: begin
				hm_we = 1'b1;
				if (up_move) hm_wdata = hm_da;
			end
			ST_DN_A: hm_we = !l_ok;
			ST_DN_C: begin
				hm_we = 1'b1;
				priority if (pick_r) hm_wdata = hm_db;
				else if (pick_l) hm_wdata = hm_da;
				else hm_wdata = cur_slot_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		stage_d = '0;
		stage_d.pending = count_q;
		stage_d.empty = (count_q == '0);
		stage_d.last = 1'b1;
		if (state_q == ST_IDLE) begin
			if (s_tuser == vtq_pkg::MODE_SCHED) begin
				stage_d.kind = vtq_pkg::KIND_SCHED;
				if (accepting_q && free_found) begin
					stage_d.accepted = 1'b1;
					stage_d.slot = free_slot;
					stage_d.version = gen_q[free_slot];
					stage_d.pending = count_q + 1'b1;
					stage_d.empty = 1'b0;
				end
			end else begin
				stage_d.kind = vtq_pkg::KIND_CANCEL;
				stage_d.accepted = cancel_ok;
				stage_d.slot = in_slot;
				stage_d.version = in_ver;
			end
		end else if (pop_go) begin
			stage_d.kind = vtq_pkg::KIND_FIRE;
			stage_d.accepted = 1'b1;
			stage_d.slot = hm_da;
			stage_d.version = gen_q[hm_da];
			stage_d.cookie = sm_cka;
			stage_d.pending = nxt_cnt;
			stage_d.empty = (nxt_cnt == '0);
			stage_d.last = 1'b0;
		end else begin
			stage_d.kind = vtq_pkg::KIND_DONE;
			stage_d.wait_us = (count_q != '0) ? wait_val : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE; ret_q <= ST_IDLE;
			accepting_q <= 1'b1; max_wait_q <= '0;
			busy_q <= '0; canc_q <= '0; count_q <= '0;
			res_v_q <= 1'b0; fired_q <= '0; fire_q <= 1'b0;
			res_q <= '0; stage_q <= '0; now_q <= '0;
			idx_q <= '0; cur_slot_q <= '0; cur_time_q <= '0;
			ha_q <= '0; hb_q <= '0;
			for (int i = 0; i < POOL; i++) gen_q[i] <= 32'd2;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[3] == vtq_pkg::REG_ACCEPTING) accepting_q <= pwdata[0];
				else if (paddr[3] == vtq_pkg::REG_MAX_WAIT) max_wait_q <= pwdata[41:0];
			end
			if (state_q == ST_OUT && res_free) begin
				res_v_q <= 1'b1;
				res_q <= stage_q;
			end else if (m_tready) res_v_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (s_tvalid && s_tready) begin
					now_q <= s_tdata[196:133] ^ {1'b1, 63'd0};
					stage_q <= stage_d;
					ret_q <= ST_IDLE;
					if (s_tuser == vtq_pkg::MODE_SCHED) begin
						if (accepting_q && free_found) begin
							busy_q[free_slot] <= 1'b1; canc_q[free_slot] <= 1'b0;
							cur_slot_q <= free_slot;
							cur_time_q <= s_tdata[63:0] ^ {1'b1, 63'd0};
							idx_q <= count_q;
							count_q <= count_q + 1'b1;
							state_q <= ST_PUSH_A;
						end else state_q <= ST_OUT;
					end else if (s_tuser == vtq_pkg::MODE_CANCEL) begin
						if (cancel_ok) canc_q[in_slot] <= 1'b1;
						state_q <= ST_OUT;
					end else if (s_tuser == vtq_pkg::MODE_TICK) begin
						fired_q <= '0;
						state_q <= ST_TOP_A;
					end
				end
				ST_PUSH_A: begin
					if (idx_q == '0) state_q <= ST_OUT;
					else begin
						ha_q <= par[SW-1:0];
						state_q <= ST_PUSH_W1;
					end
				end
				ST_PUSH_W1: state_q <= ST_PUSH_W2;
				ST_PUSH_W2: state_q <= ST_PUSH_C;
				ST_PUSH_C: begin
					if (up_move) begin
						idx_q <= par;
						state_q <= ST_PUSH_A;
					end else state_q <= ST_OUT;
				end
				ST_TOP_A: begin
					ha_q <= '0;
					state_q <= ST_TOP_W1;
				end
				ST_TOP_W1: state_q <= ST_TOP_W2;
				ST_TOP_W2: state_q <= ST_TOP_C;
				ST_TOP_C: begin
					stage_q <= stage_d;
					if (pop_go) begin
						count_q <= nxt_cnt;
						busy_q[hm_da] <= 1'b0; canc_q[hm_da] <= 1'b0;
						gen_q[hm_da] <= vtq_pkg::next_gen(gen_q[hm_da]);
						fire_q <= !canc_q[hm_da];
						if (!canc_q[hm_da]) fired_q <= fired_q + 1'b1;
						ret_q <= ST_TOP_A;
						ha_q <= nxt_cnt[SW-1:0];
						if (nxt_cnt == '0) state_q <= canc_q[hm_da] ? ST_TOP_A : ST_OUT;
						else state_q <= ST_POP_W1;
					end else begin
						ret_q <= ST_IDLE;
						state_q <= ST_OUT;
					end
				end
				ST_POP_W1: state_q <= ST_POP_W2;
				ST_POP_W2: state_q <= ST_POP_L;
				ST_POP_L: begin
					// last entry moves to the root and sinks
					cur_slot_q <= hm_da;
					cur_time_q <= sm_ta;
					idx_q <= '0;
					state_q <= ST_DN_A;
				end
				ST_DN_A: begin
					if (!l_ok) state_q <= fire_q ? ST_OUT : ST_TOP_A;
					else begin
						ha_q <= lidx[SW-1:0];
						hb_q <= ridx[SW-1:0];
						state_q <= ST_DN_W1;
					end
				end
				ST_DN_W1: state_q <= ST_DN_W2;
				ST_DN_W2: state_q <= ST_DN_C;
				ST_DN_C: begin
					priority if (pick_r) begin
						idx_q <= ridx;
						state_q <= ST_DN_A;
					end else if (pick_l) begin
						idx_q <= lidx;
						state_q <= ST_DN_A;
					end else state_q <= fire_q ? ST_OUT : ST_TOP_A;
				end
				ST_OUT: if (res_free) state_q <= ret_q;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = res_v_q;
	assign m_tuser  = res_q.kind;
	assign m_tlast  = res_q.last;
	assign m_tdata  = {4'd0, res_q.wait_us, res_q.empty, res_q.pending, res_q.cookie,
		res_q.version, res_q.slot, res_q.accepted};
	assign pready   = 1'b1;
	assign prdata   = paddr[3] ? {22'd0, max_wait_q} : {63'd0, accepting_q};

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(POOL)) else $error("heap count overflow");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(busy_q) >= count_q) else $error("busy below count");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
		&& $stable(m_tlast)) else $error("result changed while waiting");
endmodule

@@ tb/tb_versioned_timer_queue_core.sv @@
// ---------------------------------------------------------------------------
// tb_versioned_timer_queue_core
// Self-checking bench for the versioned timer queue: schedules, cancels and
// ticks are streamed in, and every reply is predicted and compared per field.
// ---------------------------------------------------------------------------
module tb_versioned_timer_queue_core;
	localparam int unsigned CYCLE_LIMIT = 800000;
	localparam int unsigned SETTLE      = 60;
	localparam logic [3:0]  ADDR_ACCEPTING = 4'(8 * vtq_pkg::REG_ACCEPTING);
	localparam logic [3:0]  ADDR_MAX_WAIT  = 4'(8 * vtq_pkg::REG_MAX_WAIT);
	localparam logic [1:0]  MODE_UNUSED    = 2'd3;
	localparam logic [41:0] CAP_TOP        = 42'd4294967295000;
	localparam logic [63:0] WAIT_SAT       = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] T_MIN   = 64'sh8000_0000_0000_0000;
	localparam logic signed [63:0] T_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;

	class timer_scoreboard;
		logic signed [63:0] due_us [32];
		logic [31:0]        cookie [32];
		logic [31:0]        gen [32];
		bit                 busy [32];
		bit                 cancelled [32];
		bit                 accepting;
		logic [41:0]        cap;
		vtq_pkg::result_t   expected_q [$];
		int                 errors;
		int                 n_results;
		int                 n_fires;

		function new();
			for (int i = 0; i < 32; i++) begin
				gen[i] = 32'd2;
				busy[i] = 0;
				cancelled[i] = 0;
			end
			accepting = 1;
			cap = '0;
			errors = 0;
			n_results = 0;
			n_fires = 0;
		endfunction

		task report(string msg);
			$display("MISMATCH: %s", msg);
			errors++;
		endtask

		function void set_config(logic [3:0] addr, logic [63:0] value);
			if (addr == ADDR_ACCEPTING) accepting = value[0];
			else if (addr == ADDR_MAX_WAIT) cap = value[41:0];
		endfunction

		function int pending();
			int n;
			n = 0;
			for (int i = 0; i < 32; i++) n += busy[i];
			return n;
		endfunction

		function int earliest();
			int s;
			s = -1;
			for (int i = 0; i < 32; i++)
				if (busy[i] && (s < 0 || due_us[i] < due_us[s])) s = i;
			return s;
		endfunction

		function void push(logic [1:0] kind, logic acc, logic [4:0] slot, logic [31:0] ver,
				logic [31:0] ck, logic [62:0] wait_val, logic last);
			vtq_pkg::result_t r;
			r.kind = kind;
			r.accepted = acc;
			r.slot = slot;
			r.version = ver;
			r.cookie = ck;
			r.pending = vtq_pkg::CNT_W'(pending());
			r.empty = (pending() == 0);
			r.wait_us = wait_val;
			r.last = last;
			expected_q = {expected_q, r};
		endfunction

		function void note_input(logic [1:0] mode, logic signed [63:0] rt, logic [31:0] ck,
				logic [4:0] tslot, logic [31:0] tver, logic signed [63:0] now);
			int s;
			int n;
			logic [63:0] wv;
			if (mode == vtq_pkg::MODE_SCHED) begin
				s = -1;
				if (accepting)
					for (int i = 31; i >= 0; i--) if (!busy[i]) s = i;
				if (s < 0) push(vtq_pkg::KIND_SCHED, 0, 0, 0, 0, 0, 1);
				else begin
					busy[s] = 1;
					cancelled[s] = 0;
					due_us[s] = rt;
					cookie[s] = ck;
					push(vtq_pkg::KIND_SCHED, 1, 5'(s), gen[s], 0, 0, 1);
				end
			end else if (mode == vtq_pkg::MODE_CANCEL) begin
				if (busy[tslot] && !cancelled[tslot] && gen[tslot] == tver) begin
					cancelled[tslot] = 1;
					push(vtq_pkg::KIND_CANCEL, 1, tslot, tver, 0, 0, 1);
				end else push(vtq_pkg::KIND_CANCEL, 0, tslot, tver, 0, 0, 1);
			end else if (mode == vtq_pkg::MODE_TICK) begin
				n = 0;
				while (n < vtq_pkg::FIRE_LIMIT) begin
					s = earliest();
					if (s < 0 || due_us[s] > now) break;
					busy[s] = 0;
					if (!cancelled[s]) begin
						push(vtq_pkg::KIND_FIRE, 1, 5'(s), gen[s], cookie[s], 0, 0);
						n++;
						n_fires++;
					end
					cancelled[s] = 0;
					gen[s] = gen[s] + 32'd2;
					if (gen[s] == 0) gen[s] = 32'd2;
				end
				wv = '0;
				s = earliest();
				if (s >= 0) begin
					if (due_us[s] > now) wv = due_us[s] - now;
					if (cap != 0 && wv > 64'(cap)) wv = 64'(cap);
					if (wv > WAIT_SAT) wv = WAIT_SAT;
				end
				push(vtq_pkg::KIND_DONE, 0, 0, 0, 0, wv[62:0], 1);
			end
		endfunction

		task field(string name, logic [63:0] got, logic [63:0] exp);
			if (got !== exp) report($sformatf("%s got %h expected %h", name, got, exp));
		endtask

		task check_result(vtq_pkg::result_t got);
			vtq_pkg::result_t e;
			n_results++;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected result kind %0d", got.kind));
				return;
			end
			e = expected_q.pop_front();
			field("reply_kind", got.kind, e.kind);
			field("accepted", got.accepted, e.accepted);
			field("slot_out", got.slot, e.slot);
			field("version_out", got.version, e.version);
			field("cookie_out", got.cookie, e.cookie);
			field("pending_count", got.pending, e.pending);
			field("heap_empty", got.empty, e.empty);
			field("wait_us", got.wait_us, e.wait_us);
			field("last", got.last, e.last);
		endtask
	endclass

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [199:0] s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [143:0] m_tdata;
	logic [1:0]   m_tuser;
	logic         m_tlast;
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [3:0]   paddr;
	logic [63:0]  pwdata;
	logic [63:0]  prdata;
	logic         pready;

	timer_scoreboard timer_sb;
	int unsigned cycle_count;
	int          idle_pct;
	int          stall_pct;
	int          n_items;
	logic signed [63:0] now_base;

	versioned_timer_queue_core u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("end of test: mismatches");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) m_tready <= ($urandom_range(0, 99) >= stall_pct);
	end

	always @(posedge clk) begin
		vtq_pkg::result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.kind = m_tuser;
			got.accepted = m_tdata[0];
			got.slot = m_tdata[5:1];
			got.version = m_tdata[37:6];
			got.cookie = m_tdata[69:38];
			got.pending = m_tdata[75:70];
			got.empty = m_tdata[76];
			got.wait_us = m_tdata[139:77];
			got.last = m_tlast;
			timer_sb.check_result(got);
		end
	end

	task automatic send_item(logic [1:0] mode, logic signed [63:0] rt, logic [31:0] ck,
			logic [4:0] tslot, logic [31:0] tver, logic signed [63:0] now);
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {3'b0, now, tver, tslot, ck, rt};
		do @(posedge clk); while (!(s_tvalid && s_tready));
		timer_sb.note_input(mode, rt, ck, tslot, tver, now);
		n_items++;
		if ($urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic schedule(logic signed [63:0] rt, logic [31:0] ck);
		send_item(vtq_pkg::MODE_SCHED, rt, ck, 5'($urandom), $urandom, {$urandom, $urandom});
	endtask

	task automatic cancel(logic [4:0] tslot, logic [31:0] tver);
		send_item(vtq_pkg::MODE_CANCEL, {$urandom, $urandom}, $urandom, tslot, tver,
			{$urandom, $urandom});
	endtask

	task automatic tick(logic signed [63:0] now);
		send_item(vtq_pkg::MODE_TICK, {$urandom, $urandom}, $urandom, 5'($urandom), $urandom,
			now);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (timer_sb.expected_q.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [3:0] addr, logic [63:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		timer_sb.set_config(addr, value);
	endtask

	task automatic random_item();
		int r;
		logic [4:0] s;
		logic [31:0] v;
		r = $urandom_range(0, 99);
		if (r < 45) begin
			if ($urandom_range(0, 9) == 0) schedule({$urandom, $urandom}, $urandom);
			else schedule(now_base + $urandom_range(0, 2000) - 100, $urandom);
		end else if (r < 70) begin
			s = 5'($urandom);
			case ($urandom_range(0, 3))
				0: v = $urandom;
				1: v = timer_sb.gen[s] - 32'd2;
				default: v = timer_sb.gen[s];
			endcase
			cancel(s, v);
		end else if (r < 97) begin
			now_base = now_base + $urandom_range(0, 700);
			tick(now_base);
		end else if (r < 99) begin
			tick(T_MAX);
		end else begin
			send_item(MODE_UNUSED, {$urandom, $urandom}, $urandom, 5'($urandom), $urandom,
				{$urandom, $urandom});
		end
	endtask

	initial begin
		logic [63:0] caps [4];
		timer_sb = new();
		cycle_count = 0;
		n_items = 0;
		idle_pct = 0;
		stall_pct = 0;
		now_base = 64'sd1000;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: time extremes, every cancel refusal, silent drop, unused mode
		schedule(T_MIN, 32'h0);
		schedule(T_MAX, 32'hFFFF_FFFF);
		schedule(64'sd0, $urandom);
		cancel(5'd2, 32'd2);
		cancel(5'd2, 32'd2);
		cancel(5'd1, 32'hFFFF_FFFF);
		cancel(5'd31, 32'd2);
		send_item(MODE_UNUSED, T_MAX, 32'hFFFF_FFFF, 5'd31, 32'hFFFF_FFFF, T_MAX);
		tick(T_MIN);
		tick(64'sd0);
		tick(T_MAX);
		tick(T_MAX);
		drain();
		write_reg(ADDR_ACCEPTING, 64'd0);
		schedule(64'sd5, 32'h1234);
		drain();
		write_reg(ADDR_ACCEPTING, 64'd1);
		write_reg(ADDR_MAX_WAIT, 64'(CAP_TOP));
		for (int i = 0; i < 33; i++) schedule(64'sd100 + $urandom_range(0, 3), $urandom);
		tick(64'sd101);
		drain();
		write_reg(ADDR_MAX_WAIT, 64'd1);
		tick(64'sd0);
		tick(T_MAX);
		drain();

		caps[0] = 64'd0;
		caps[1] = 64'(CAP_TOP);
		caps[2] = 64'($urandom_range(1, 5000));
		caps[3] = {$urandom, $urandom};
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 75; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 75; end
				default: begin idle_pct = 36; stall_pct = 36; end
			endcase
			write_reg(ADDR_MAX_WAIT, caps[ph]);
			write_reg(ADDR_ACCEPTING, 64'(ph != 1 || $urandom_range(0, 1)));
			for (int i = 0; i < 18; i++) begin
				if (i == 9) drain();
				random_item();
			end
			drain();
			write_reg(ADDR_ACCEPTING, 64'd1);
		end

		drain();
		$display("covered %0d items, %0d results, %0d fired timers, four idle/stall mixes",
			n_items, timer_sb.n_results, timer_sb.n_fires);
		if (timer_sb.errors == 0 && timer_sb.expected_q.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatches, %0d results outstanding", timer_sb.errors,
				timer_sb.expected_q.size());
			$display("end of test: mismatches");
		end
		$finish;
	end
endmodule
